@@ hdl/qcc_pkg.sv @@
// Shared types, constants and a helper function for the queen conflict counter.
// Used by the controller, the datapath, the top level and the checker.
package qcc_pkg;

  localparam int ROW_W          = 7;   // row index width, also the board size register width
  localparam int COL_W          = 6;
  localparam int FROW_W         = 6;   // width of the row fields of an item
  localparam int TOT_W          = 11;
  localparam int DELTA_W        = 8;
  localparam int DACC_W         = 10;  // delta accumulator, holds +/-2 per row over 127 rows
  localparam int MAX_QUEENS_DEF = 64;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam logic [ROW_W-1:0]   BOARD_SIZE_RST  = 7'd8;
  localparam logic [PADDR_W-1:0] ADDR_BOARD_SIZE = 3'd0;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_COUNT = 2'd1;
  localparam logic [1:0] CMD_SWAP  = 2'd2;

  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_SWAP  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_PIV,
    S_T_CAP,
    S_T_SCAN,
    S_T_DRAIN,
    S_D_RA,
    S_D_RB,
    S_D_CAPB,
    S_D_SCAN,
    S_D_DRAIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    RD_PIVOT,
    RD_SECOND,
    RD_SCAN
  } rd_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    rd_sel_t rd_sel;
    logic    cap_ca;
    logic    cap_cb;
    logic    scan_init;
    logic    scan_step;
    logic    piv_inc;
    logic    out_fire;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic trivial;    // item needs no board walk, result is zero
    logic scan_last;
    logic piv_last;
  } sts_t;

  // Queens in different rows attack on a shared column or diagonal.
  function automatic logic attacks(input logic [ROW_W-1:0] ra, input logic [COL_W-1:0] ca,
                                   input logic [ROW_W-1:0] rb, input logic [COL_W-1:0] cb);
    logic [ROW_W-1:0] dr;
    logic [COL_W-1:0] dc;
    dr = (ra > rb) ? (ra - rb) : (rb - ra);
    dc = (ca > cb) ? (ca - cb) : (cb - ca);
    return (ca == cb) || (dr == ROW_W'(dc));
  endfunction

endpackage

@@ hdl/qcc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qcc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/qcc_datapath.sv @@
// Datapath: column store, row counters, attack checks, accumulators, result registers.
// Depends on qcc_pkg and qcc_ram.
module qcc_datapath #(
  parameter int MAX_QUEENS = qcc_pkg::MAX_QUEENS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [qcc_pkg::ROW_W-1:0]   board_size,
  input  logic [1:0]                  in_command,
  input  logic [qcc_pkg::FROW_W-1:0]  in_first_row,
  input  logic [qcc_pkg::FROW_W-1:0]  in_second_row,
  input  logic [qcc_pkg::COL_W-1:0]   in_load_column,
  input  qcc_pkg::ctl_t               ctl,
  output qcc_pkg::sts_t               sts,
  output logic                        out_valid,
  output logic [qcc_pkg::TOT_W-1:0]   out_total_threats,
  output logic signed [qcc_pkg::DELTA_W-1:0] out_swap_delta,
  output logic                        out_result_kind
);

  localparam int AW = $clog2(MAX_QUEENS);
  localparam int RW = qcc_pkg::ROW_W;
  localparam int CW = qcc_pkg::COL_W;
  localparam int DW = qcc_pkg::DACC_W;

  logic [RW-1:0] n;
  logic [RW-1:0] first_ext, second_ext;

  logic [RW-1:0] piv_r, piv_nxt;
  logic [RW-1:0] sec_r, sec_nxt;
  logic [RW-1:0] scan_r, scan_nxt;
  logic [RW-1:0] tag_r;
  logic          eval_r;
  logic          kind_r, kind_nxt;
  logic [CW-1:0] ca_r, cb_r;

  logic [qcc_pkg::TOT_W-1:0] tot_r, tot_nxt;
  logic signed [DW-1:0]      dacc_r, dacc_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] rd_data;
  logic [RW-1:0] rd_row;

  logic          hit_total;
  logic [CW-1:0] c_after;
  logic [1:0]    bef, aft;

  logic                      out_valid_r;
  logic [qcc_pkg::TOT_W-1:0] out_tot_r;
  logic signed [qcc_pkg::DELTA_W-1:0] out_delta_r;
  logic                      out_kind_r;
  logic signed [qcc_pkg::DELTA_W-1:0] delta_sat;

  assign first_ext  = RW'(in_first_row);
  assign second_ext = RW'(in_second_row);
  assign n = (32'(board_size) > MAX_QUEENS) ? RW'(MAX_QUEENS) : board_size;

  assign sts.trivial = (in_command == qcc_pkg::CMD_SWAP) ?
                       ((first_ext == second_ext) || (first_ext >= n) || (second_ext >= n)) :
                       (n < RW'(2));
  assign sts.scan_last = (scan_r == n - RW'(1));
  assign sts.piv_last  = ({1'b0, piv_r} + (RW+1)'(2)) >= {1'b0, n};

  // column store
  assign ram_we    = ctl.accept && (in_command == qcc_pkg::CMD_LOAD) &&
                     (32'(in_first_row) < MAX_QUEENS);
  assign ram_waddr = AW'(in_first_row);

  always_comb begin
    unique case (ctl.rd_sel)
      qcc_pkg::RD_PIVOT:  rd_row = piv_r;
      qcc_pkg::RD_SECOND: rd_row = sec_r;
      qcc_pkg::RD_SCAN:   rd_row = scan_r;
      default:            rd_row = scan_r;
    endcase
  end
  assign ram_raddr = AW'(rd_row);

  qcc_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_QUEENS)
  ) u_qcc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_load_column),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // row counters and operand latches
  always_comb begin
    piv_nxt  = piv_r;
    sec_nxt  = sec_r;
    kind_nxt = kind_r;
    scan_nxt = scan_r;
    if (ctl.accept) begin
      piv_nxt  = (in_command == qcc_pkg::CMD_SWAP) ? first_ext : '0;
      sec_nxt  = second_ext;
      kind_nxt = (in_command == qcc_pkg::CMD_SWAP) ? qcc_pkg::KIND_SWAP : qcc_pkg::KIND_TOTAL;
    end
    if (ctl.piv_inc) begin
      piv_nxt = piv_r + RW'(1);
    end
    if (ctl.scan_init) begin
      scan_nxt = (kind_r == qcc_pkg::KIND_SWAP) ? '0 : piv_r + RW'(1);
    end else if (ctl.scan_step) begin
      scan_nxt = scan_r + RW'(1);
    end
  end

  // evaluation of the row read in the previous cycle
  always_comb begin
    hit_total = qcc_pkg::attacks(piv_r, ca_r, tag_r, rd_data);
    if (tag_r == piv_r) begin
      c_after = cb_r;
    end else if (tag_r == sec_r) begin
      c_after = ca_r;
    end else begin
      c_after = rd_data;
    end
    bef = '0;
    aft = '0;
    if (tag_r != piv_r) begin
      bef = bef + 2'(qcc_pkg::attacks(piv_r, ca_r, tag_r, rd_data));
      aft = aft + 2'(qcc_pkg::attacks(piv_r, cb_r, tag_r, c_after));
    end
    if (tag_r != sec_r) begin
      bef = bef + 2'(qcc_pkg::attacks(sec_r, cb_r, tag_r, rd_data));
      aft = aft + 2'(qcc_pkg::attacks(sec_r, ca_r, tag_r, c_after));
    end
  end

  always_comb begin
    tot_nxt  = tot_r;
    dacc_nxt = dacc_r;
    if (ctl.accept) begin
      tot_nxt  = '0;
      dacc_nxt = '0;
    end else if (eval_r) begin
      if (kind_r == qcc_pkg::KIND_SWAP) begin
        dacc_nxt = dacc_r + $signed({{(DW-2){1'b0}}, aft}) - $signed({{(DW-2){1'b0}}, bef});
      end else if (hit_total && (tot_r != {qcc_pkg::TOT_W{1'b1}})) begin
        tot_nxt = tot_r + qcc_pkg::TOT_W'(1);
      end
    end
  end

  always_comb begin
    if (dacc_r > DW'(127)) begin
      delta_sat = 8'sd127;
    end else if (dacc_r < -DW'(128)) begin
      delta_sat = -8'sd128;
    end else begin
      delta_sat = dacc_r[qcc_pkg::DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      eval_r      <= ctl.scan_step;
      out_valid_r <= ctl.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    piv_r  <= piv_nxt;
    sec_r  <= sec_nxt;
    kind_r <= kind_nxt;
    scan_r <= scan_nxt;
    tag_r  <= scan_r;
    tot_r  <= tot_nxt;
    dacc_r <= dacc_nxt;
    if (ctl.cap_ca) begin
      ca_r <= rd_data;
    end
    if (ctl.cap_cb) begin
      cb_r <= rd_data;
    end
    if (ctl.out_fire) begin
      out_kind_r  <= kind_r;
      out_tot_r   <= (kind_r == qcc_pkg::KIND_SWAP) ? '0 : tot_r;
      out_delta_r <= (kind_r == qcc_pkg::KIND_SWAP) ? delta_sat : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_total_threats = out_tot_r;
  assign out_swap_delta    = out_delta_r;
  assign out_result_kind   = out_kind_r;

endmodule

@@ hdl/qcc_ctrl.sv @@
// Controller state machine: sequences pivot reads, row scans and the result strobe.
// Depends on qcc_pkg.
module qcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_command,
  input  qcc_pkg::sts_t sts,
  output qcc_pkg::ctl_t ctl,
  output logic          busy
);

  qcc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qcc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.rd_sel    = qcc_pkg::RD_SCAN;
    busy          = 1'b1;
    unique case (state_r)
      qcc_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.accept = 1'b1;
          case (in_command)
            qcc_pkg::CMD_COUNT: state_nxt = sts.trivial ? qcc_pkg::S_OUT : qcc_pkg::S_T_PIV;
            qcc_pkg::CMD_SWAP:  state_nxt = sts.trivial ? qcc_pkg::S_OUT : qcc_pkg::S_D_RA;
            default:            state_nxt = qcc_pkg::S_IDLE;
          endcase
        end
      end
      qcc_pkg::S_T_PIV: begin
        ctl.rd_sel = qcc_pkg::RD_PIVOT;
        state_nxt  = qcc_pkg::S_T_CAP;
      end
      qcc_pkg::S_T_CAP: begin
        ctl.cap_ca    = 1'b1;
        ctl.scan_init = 1'b1;
        state_nxt     = qcc_pkg::S_T_SCAN;
      end
      qcc_pkg::S_T_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = qcc_pkg::S_T_DRAIN;
        end
      end
      qcc_pkg::S_T_DRAIN: begin
        // last pair of this pivot is evaluated here
        if (sts.piv_last) begin
          state_nxt = qcc_pkg::S_OUT;
        end else begin
          ctl.piv_inc = 1'b1;
          state_nxt   = qcc_pkg::S_T_PIV;
        end
      end
      qcc_pkg::S_D_RA: begin
        ctl.rd_sel = qcc_pkg::RD_PIVOT;
        state_nxt  = qcc_pkg::S_D_RB;
      end
      qcc_pkg::S_D_RB: begin
        ctl.cap_ca = 1'b1;
        ctl.rd_sel = qcc_pkg::RD_SECOND;
        state_nxt  = qcc_pkg::S_D_CAPB;
      end
      qcc_pkg::S_D_CAPB: begin
        ctl.cap_cb    = 1'b1;
        ctl.scan_init = 1'b1;
        state_nxt     = qcc_pkg::S_D_SCAN;
      end
      qcc_pkg::S_D_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = qcc_pkg::S_D_DRAIN;
        end
      end
      qcc_pkg::S_D_DRAIN: begin
        state_nxt = qcc_pkg::S_OUT;
      end
      qcc_pkg::S_OUT: begin
        ctl.out_fire = 1'b1;
        state_nxt    = qcc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = qcc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/queen_conflict_counter_unit.sv @@
// Queen conflict counter top level: APB board size register, controller, datapath.
// Depends on qcc_pkg, qcc_ctrl, qcc_datapath (and qcc_ram through the datapath).
// Load: no result. Count: the time from accept to strobe is set by one column-store read port
// visiting every row pair. Swap delta: one scan over the rows. Trivial queries skip the scan.
// One item at a time; busy is high while an item is in progress. Synchronous active-low
// reset clears control state and sets board_size to 8; the column store is not cleared.
module queen_conflict_counter_unit #(
  parameter int MAX_QUEENS = qcc_pkg::MAX_QUEENS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [qcc_pkg::FROW_W-1:0]   in_first_row,
  input  logic [qcc_pkg::FROW_W-1:0]   in_second_row,
  input  logic [qcc_pkg::COL_W-1:0]    in_load_column,
  output logic                         out_valid,
  output logic [qcc_pkg::TOT_W-1:0]    out_total_threats,
  output logic signed [qcc_pkg::DELTA_W-1:0] out_swap_delta,
  output logic                         out_result_kind,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [qcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [qcc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  logic [qcc_pkg::ROW_W-1:0] board_size_r;
  qcc_pkg::ctl_t ctl;
  qcc_pkg::sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= qcc_pkg::BOARD_SIZE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == qcc_pkg::ADDR_BOARD_SIZE)) begin
      board_size_r <= pwdata[qcc_pkg::ROW_W-1:0];
    end
  end

  assign prdata = (paddr == qcc_pkg::ADDR_BOARD_SIZE) ?
                  qcc_pkg::PDATA_W'(board_size_r) : '0;

  qcc_ctrl u_qcc_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  qcc_datapath #(
    .MAX_QUEENS(MAX_QUEENS)
  ) u_qcc_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .board_size        (board_size_r),
    .in_command        (in_command),
    .in_first_row      (in_first_row),
    .in_second_row     (in_second_row),
    .in_load_column    (in_load_column),
    .ctl               (ctl),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_total_threats (out_total_threats),
    .out_swap_delta    (out_swap_delta),
    .out_result_kind   (out_result_kind)
  );

endmodule

@@ hdl/qcc_checker.sv @@
// Port-level checker for the queen conflict counter, bound to the top level.
// Depends on qcc_pkg and queen_conflict_counter_unit.
module qcc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [1:0]                          in_command,
  input logic                                out_valid,
  input logic [qcc_pkg::TOT_W-1:0]           out_total_threats,
  input logic signed [qcc_pkg::DELTA_W-1:0]  out_swap_delta,
  input logic                                out_result_kind
);

  // a result strobe is a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // results only appear once the item is finished
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // a load item finishes at once and produces nothing
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == qcc_pkg::CMD_LOAD) |=> (!busy && !out_valid))
    else $error("load item did not complete in one cycle");

  // count and swap items occupy the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == qcc_pkg::CMD_COUNT ||
                        in_command == qcc_pkg::CMD_SWAP)) |=> busy)
    else $error("query item did not raise busy");

  // the unused result field is zero
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == qcc_pkg::KIND_SWAP) ? (out_total_threats == '0)
                                                           : (out_swap_delta == '0)))
    else $error("inactive result field not zero");

endmodule

bind queen_conflict_counter_unit qcc_checker u_qcc_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for queen_conflict_counter_unit: board loads, threat totals, swap deltas.
// Drives items and the board_size register, predicts each result in place. Needs qcc_pkg.
module tb_top;
  import qcc_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int COUNT_TAIL = 2300;  // longest count latency at 64 rows, plus margin
  localparam logic [1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [TOT_W-1:0]          total;
    logic signed [DELTA_W-1:0] delta;
    logic                      kind;
  } threat_report_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FROW_W-1:0]  row_a;
    logic [FROW_W-1:0]  row_b;
    logic [COL_W-1:0]   column;
    logic               typed;  // expected result written in the table
    logic [TOT_W-1:0]   total;
    logic [DELTA_W-1:0] delta;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = CMD_NOP;
  logic [FROW_W-1:0] in_first_row = '0;
  logic [FROW_W-1:0] in_second_row = '0;
  logic [COL_W-1:0] in_load_column = '0;
  logic out_valid;
  logic [TOT_W-1:0] out_total_threats;
  logic signed [DELTA_W-1:0] out_swap_delta;
  logic out_result_kind;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // shadow of the block's board and register
  logic [COL_W-1:0] board_cols [MAX_QUEENS_DEF];
  bit               row_loaded [MAX_QUEENS_DEF];
  logic [ROW_W-1:0] board_size_set = BOARD_SIZE_RST;

  threat_report_t reports_due[$];
  stim_row_t      directed_rows[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  queen_conflict_counter_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_first_row(in_first_row), .in_second_row(in_second_row),
    .in_load_column(in_load_column),
    .out_valid(out_valid), .out_total_threats(out_total_threats),
    .out_swap_delta(out_swap_delta), .out_result_kind(out_result_kind),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int rows_active();
    return (board_size_set > MAX_QUEENS_DEF) ? MAX_QUEENS_DEF : int'(board_size_set);
  endfunction

  function automatic bit queens_clash(int ra, int ca, int rb, int cb);
    int dr, dc;
    dr = (ra > rb) ? ra - rb : rb - ra;
    dc = (ca > cb) ? ca - cb : cb - ca;
    return (ca == cb) || (dr == dc);
  endfunction

  function automatic int col_seen(int r, int a, int b, bit swapped);
    if (swapped && r == a) return int'(board_cols[b]);
    if (swapped && r == b) return int'(board_cols[a]);
    return int'(board_cols[r]);
  endfunction

  // threats of row a and of row b against all other rows; the a-b pair lands in both halves
  function automatic int pair_threats(int n, int a, int b, bit swapped);
    int sum, me, mc;
    sum = 0;
    for (int k = 0; k < 2; k++) begin
      me = (k == 0) ? a : b;
      mc = col_seen(me, a, b, swapped);
      for (int r = 0; r < n; r++) begin
        if (r != me && queens_clash(me, mc, r, col_seen(r, a, b, swapped))) sum++;
      end
    end
    return sum;
  endfunction

  // applies one accepted item to the shadow board; returns 1 when a result is due
  function automatic bit predict_threats(input stim_row_t item, output threat_report_t rep);
    int n, a, b, total, delta;
    n = rows_active();
    a = int'(item.row_a);
    b = int'(item.row_b);
    rep.total = '0;
    rep.delta = '0;
    rep.kind = KIND_TOTAL;
    case (item.cmd)
      CMD_LOAD: begin
        board_cols[a] = item.column;
        row_loaded[a] = 1'b1;
        return 1'b0;
      end
      CMD_COUNT: begin
        total = 0;
        for (int i = 0; i < n; i++) begin
          for (int j = i + 1; j < n; j++) begin
            if (queens_clash(i, int'(board_cols[i]), j, int'(board_cols[j]))) total++;
          end
        end
        rep.total = (total > 2047) ? 11'd2047 : TOT_W'(total);
        return 1'b1;
      end
      CMD_SWAP: begin
        delta = 0;
        if (a != b && a < n && b < n)
          delta = pair_threats(n, a, b, 1'b1) - pair_threats(n, a, b, 1'b0);
        if (delta > 127) delta = 127;
        if (delta < -128) delta = -128;
        rep.delta = DELTA_W'(delta);
        rep.kind = KIND_SWAP;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    threat_report_t want;
    if (rst_n && out_valid) begin
      if (reports_due.size() == 0) begin
        $error("result with none pending: total_threats %0d swap_delta %0d result_kind %0d",
               out_total_threats, out_swap_delta, out_result_kind);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        if (out_total_threats !== want.total) begin
          $error("total_threats: expected %0d, got %0d", want.total, out_total_threats);
          mismatch_count++;
        end
        if (out_swap_delta !== want.delta) begin
          $error("swap_delta: expected %0d, got %0d", want.delta, out_swap_delta);
          mismatch_count++;
        end
        if (out_result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_result_kind);
          mismatch_count++;
        end
      end
    end
  end

  task automatic issue_item(input stim_row_t item, input int gap);
    threat_report_t rep;
    bit yields;
    @(negedge clk);
    start <= 1'b1;
    in_command <= item.cmd;
    in_first_row <= item.row_a;
    in_second_row <= item.row_b;
    in_load_column <= item.column;
    do @(posedge clk); while (busy);
    yields = predict_threats(item, rep);
    if (yields && item.typed) begin
      rep.total = item.total;
      rep.delta = item.delta;
    end
    if (yields) reports_due.push_back(rep);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic add_row(input logic [1:0] cmd, input int a, input int b, input int col,
                         input bit typed = 1'b0, input int total = 0, input int delta = 0);
    stim_row_t row;
    row.cmd = cmd;
    row.row_a = FROW_W'(a);
    row.row_b = FROW_W'(b);
    row.column = COL_W'(col);
    row.typed = typed;
    row.total = TOT_W'(total);
    row.delta = DELTA_W'(delta);
    directed_rows.push_back(row);
  endtask

  // block must be idle before the register is touched
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_board_size();
    logic [PDATA_W-1:0] rd;
    cfg_access(1'b0, ADDR_BOARD_SIZE, '0, rd);
    if (rd !== PDATA_W'(board_size_set)) begin
      $error("board_size: expected %0d, got %0d", board_size_set, rd);
      mismatch_count++;
    end
  endtask

  task automatic set_board_size(input int size);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    cfg_access(1'b1, ADDR_BOARD_SIZE, PDATA_W'(size), rd);
    board_size_set = ROW_W'(size);
    check_board_size();
  endtask

  task automatic run_phase(input int size, input int items);
    stim_row_t row;
    int n, pick, gap;
    bit burst;
    set_board_size(size);
    n = rows_active();
    burst = ($urandom_range(0, 2) == 0);
    row = '0;
    // every row in use gets a column before anything reads the board
    for (int r = 0; r < n; r++) begin
      if (!row_loaded[r]) begin
        row.cmd = CMD_LOAD;
        row.row_a = FROW_W'(r);
        row.column = COL_W'($urandom_range(0, n - 1));
        issue_item(row, burst ? 0 : $urandom_range(0, 15));
      end
    end
    for (int k = 0; k < items; k++) begin
      row = '0;
      row.row_a = FROW_W'($urandom_range(0, 63));
      row.row_b = FROW_W'($urandom_range(0, 63));
      row.column = COL_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        row.cmd = CMD_LOAD;
        if (n > 0 && $urandom_range(0, 4) != 0) row.row_a = FROW_W'($urandom_range(0, n - 1));
        if (n > 0 && $urandom_range(0, 9) < 7) row.column = COL_W'($urandom_range(0, n - 1));
      end else if (pick < 55) begin
        row.cmd = CMD_COUNT;
      end else if (pick < 95) begin
        row.cmd = CMD_SWAP;
        if (n > 0 && $urandom_range(0, 9) < 8) begin
          row.row_a = FROW_W'($urandom_range(0, n - 1));
          row.row_b = ($urandom_range(0, 7) == 0) ? row.row_a : FROW_W'($urandom_range(0, n - 1));
        end
      end else begin
        row.cmd = CMD_NOP;
      end
      gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      issue_item(row, gap);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_board_size();

    // main diagonal on an 8-row board: every pair clashes
    for (int r = 0; r < 8; r++) add_row(CMD_LOAD, r, 0, r);
    add_row(CMD_COUNT, 0, 0, 0, 1'b1, 28, 0);
    add_row(CMD_SWAP, 3, 3, 0, 1'b1, 0, 0);
    add_row(CMD_SWAP, 5, 63, 0, 1'b1, 0, 0);
    add_row(CMD_NOP, 63, 63, 63);
    add_row(CMD_LOAD, 63, 0, 63);  // outside the board, still stored
    add_row(CMD_LOAD, 0, 0, 63);
    add_row(CMD_COUNT, 0, 0, 0);
    add_row(CMD_SWAP, 0, 7, 0);
    add_row(CMD_SWAP, 7, 0, 0);
    add_row(CMD_SWAP, 63, 0, 0, 1'b1, 0, 0);
    add_row(CMD_LOAD, 4, 0, 2);
    add_row(CMD_SWAP, 2, 4, 0);
    add_row(CMD_COUNT, 0, 0, 0);
    foreach (directed_rows[i]) issue_item(directed_rows[i], 0);

    run_phase(1, 25);
    run_phase(64, 30);
    run_phase(0, 20);
    run_phase(127, 30);
    run_phase(2, 25);
    run_phase($urandom_range(3, 20), 28);
    run_phase($urandom_range(3, 20), 28);
    run_phase($urandom_range(21, 63), 28);

    wait_idle();
    repeat (COUNT_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
